### rtl/core/tcw_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the text console writer
package tcw_pkg;

  // operation codes of an input transaction
  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // control sequencer states
  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_CLEAR,
    ST_SCROLL,
    ST_DRAIN
  } state_t;

  // special character bytes
  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_SPACE     = 8'd32;

  // attribute after reset
  localparam logic [7:0] RESET_COLOR = 8'h07;

  // register file: text colour is register 0
  localparam logic [2:0] CFG_TEXT_COLOR_ADDR = 3'd0;

endpackage

### rtl/core/text_console_writer_unit.sv
`timescale 1ns / 1ps
// text console writer: screen store, cursor and control sequencer
// Put and newline without a scroll, backspace, unused op and out-of-range read strobe
// the result in the cycle after acceptance, one per cycle; an in-range read reports
// from ST_READ after one memory read. Clear and scroll go through ST_CLEAR, or
// ST_SCROLL and ST_DRAIN, one cell per cycle through the single write port of the
// screen memory. After reset a clearing pass blanks the store with busy high;
// results cannot be held off, each is shown on out_valid for exactly one cycle.
module text_console_writer_unit #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic        clk,
  input  logic        rst_n,
  // input transactions
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_op,
  input  logic [7:0]  in_char_code,
  input  logic [4:0]  in_read_row,
  input  logic [6:0]  in_read_col,
  // results
  output logic        out_valid,
  output logic [7:0]  out_cell_char,
  output logic [7:0]  out_cell_color,
  output logic [4:0]  out_cursor_row,
  output logic [6:0]  out_cursor_col,
  output logic [10:0] out_cursor_linear,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int SW    = $clog2(CELLS + COLUMNS);
  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLUMNS);

  tcw_pkg::state_t state_r, state_nxt;
  logic [SW-1:0]   cnt_r, cnt_nxt;
  logic [RW-1:0]   row_r, row_nxt;
  logic [CW-1:0]   col_r, col_nxt;
  logic [7:0]      color_r;
  logic            out_valid_r, out_valid_nxt;
  logic [7:0]      out_char_r, out_char_nxt;
  logic [7:0]      out_color_r, out_color_nxt;
  logic            pend_r, pend_nxt;
  logic            pend_blank_r, pend_blank_nxt;
  logic [AW-1:0]   pend_addr_r, pend_addr_nxt;

  logic [15:0]     screen_mem [CELLS];
  logic [15:0]     rd_data_r;
  logic            mem_we;
  logic [AW-1:0]   mem_wa;
  logic [AW-1:0]   mem_ra;
  logic [15:0]     mem_wd;

  logic            accept;
  logic            cfg_wr;
  logic            read_in_range;
  logic [AW-1:0]   cur_base;
  logic [AW-1:0]   read_addr;
  logic [15:0]     blank_cell;
  logic [15:0]     lin_ext;
  logic [7:0]      row_ext;
  logic [7:0]      col_ext;

  // handshake
  assign busy   = (state_r != tcw_pkg::ST_IDLE);
  assign accept = start && !busy;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == tcw_pkg::CFG_TEXT_COLOR_ADDR);
  assign prdata = (paddr == tcw_pkg::CFG_TEXT_COLOR_ADDR) ? {24'd0, color_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_r <= tcw_pkg::RESET_COLOR;
    end else if (cfg_wr) begin
      color_r <= pwdata[7:0];
    end
  end

  // address arithmetic
  assign cur_base      = AW'(32'(row_r) * COLUMNS);
  assign read_addr     = AW'(32'(in_read_row) * COLUMNS + 32'(in_read_col));
  assign read_in_range = (32'(in_read_row) < ROWS) && (32'(in_read_col) < COLUMNS);
  assign blank_cell    = {color_r, tcw_pkg::CH_SPACE};

  // cursor as reported
  assign row_ext           = 8'(row_r);
  assign col_ext           = 8'(col_r);
  assign lin_ext           = 16'(cur_base) + 16'(col_r);
  assign out_cursor_row    = row_ext[4:0];
  assign out_cursor_col    = col_ext[6:0];
  assign out_cursor_linear = lin_ext[10:0];
  assign out_valid         = out_valid_r;
  assign out_cell_char     = out_char_r;
  assign out_cell_color    = out_color_r;

  // screen memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      screen_mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= screen_mem[mem_ra];
  end

  // next state and memory control
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    row_nxt        = row_r;
    col_nxt        = col_r;
    out_valid_nxt  = 1'b0;
    out_char_nxt   = out_char_r;
    out_color_nxt  = out_color_r;
    pend_nxt       = 1'b0;
    pend_blank_nxt = 1'b0;
    pend_addr_nxt  = pend_addr_r;
    mem_we         = 1'b0;
    mem_wa         = cur_base + AW'(col_r);
    mem_wd         = blank_cell;
    mem_ra         = read_addr;

    // delayed write of the scroll copy
    if (pend_r) begin
      mem_we = 1'b1;
      mem_wa = pend_addr_r;
      mem_wd = pend_blank_r ? blank_cell : rd_data_r;
    end

    case (state_r)
      tcw_pkg::ST_INIT: begin
        mem_we = 1'b1;
        mem_wa = cnt_r[AW-1:0];
        mem_wd = {tcw_pkg::RESET_COLOR, tcw_pkg::CH_SPACE};
        if (cnt_r == SW'(CELLS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = tcw_pkg::ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      tcw_pkg::ST_IDLE: begin
        if (accept) begin
          out_char_nxt  = 8'd0;
          out_color_nxt = 8'd0;
          out_valid_nxt = 1'b1;
          case (in_op)
            tcw_pkg::OP_PUT: begin
              if (in_char_code == tcw_pkg::CH_NEWLINE) begin
                col_nxt = '0;
                if (row_r == RW'(ROWS - 1)) begin
                  state_nxt     = tcw_pkg::ST_SCROLL;
                  out_valid_nxt = 1'b0;
                end else begin
                  row_nxt = row_r + 1'b1;
                end
              end else if (in_char_code == tcw_pkg::CH_BACKSPACE) begin
                if (col_r != '0) begin
                  col_nxt = col_r - 1'b1;
                  mem_we  = 1'b1;
                  mem_wa  = cur_base + AW'(col_r) - 1'b1;
                end else if (row_r != '0) begin
                  row_nxt = row_r - 1'b1;
                  col_nxt = CW'(COLUMNS - 1);
                  mem_we  = 1'b1;
                  mem_wa  = cur_base - 1'b1;
                end
              end else begin
                mem_we = 1'b1;
                mem_wd = {color_r, in_char_code};
                if (col_r == CW'(COLUMNS - 1)) begin
                  col_nxt = '0;
                  if (row_r == RW'(ROWS - 1)) begin
                    state_nxt     = tcw_pkg::ST_SCROLL;
                    out_valid_nxt = 1'b0;
                  end else begin
                    row_nxt = row_r + 1'b1;
                  end
                end else begin
                  col_nxt = col_r + 1'b1;
                end
              end
              // scroll leaves the cursor at the start of the bottom row
              if (state_nxt == tcw_pkg::ST_SCROLL) begin
                cnt_nxt = SW'(COLUMNS);
                row_nxt = RW'(ROWS - 1);
              end
            end
            tcw_pkg::OP_READ: begin
              if (read_in_range) begin
                state_nxt     = tcw_pkg::ST_READ;
                out_valid_nxt = 1'b0;
              end
            end
            tcw_pkg::OP_CLEAR: begin
              state_nxt     = tcw_pkg::ST_CLEAR;
              out_valid_nxt = 1'b0;
              cnt_nxt       = '0;
              row_nxt       = '0;
              col_nxt       = '0;
            end
            default: begin
            end
          endcase
        end
      end

      tcw_pkg::ST_READ: begin
        out_char_nxt  = rd_data_r[7:0];
        out_color_nxt = rd_data_r[15:8];
        out_valid_nxt = 1'b1;
        state_nxt     = tcw_pkg::ST_IDLE;
      end

      tcw_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = cnt_r[AW-1:0];
        mem_wd = blank_cell;
        if (cnt_r == SW'(CELLS - 1)) begin
          cnt_nxt       = '0;
          out_valid_nxt = 1'b1;
          state_nxt     = tcw_pkg::ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      // read one row ahead, write back in the next cycle; bottom row filled blank
      tcw_pkg::ST_SCROLL: begin
        mem_ra         = (cnt_r < SW'(CELLS)) ? cnt_r[AW-1:0] : '0;
        pend_nxt       = 1'b1;
        pend_blank_nxt = (cnt_r >= SW'(CELLS));
        pend_addr_nxt  = AW'(cnt_r - SW'(COLUMNS));
        if (cnt_r == SW'(CELLS + COLUMNS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = tcw_pkg::ST_DRAIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      tcw_pkg::ST_DRAIN: begin
        out_valid_nxt = 1'b1;
        state_nxt     = tcw_pkg::ST_IDLE;
      end

      default: begin
        state_nxt = tcw_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tcw_pkg::ST_INIT;
      cnt_r       <= '0;
      row_r       <= '0;
      col_r       <= '0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    out_char_r   <= out_char_nxt;
    out_color_r  <= out_color_nxt;
    pend_blank_r <= pend_blank_nxt;
    pend_addr_r  <= pend_addr_nxt;
  end

endmodule

### rtl/core/tcw_checker.sv
`timescale 1ns / 1ps
// port-level checks of the text console writer and their binding
module tcw_checker #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [1:0]  in_op,
  input logic [4:0]  in_read_row,
  input logic [6:0]  in_read_col,
  input logic        out_valid,
  input logic [4:0]  out_cursor_row,
  input logic [6:0]  out_cursor_col,
  input logic [10:0] out_cursor_linear
);

  // clearing pass follows reset
  a_reset_busy: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("not busy after reset");

  // reported cursor stays on the screen
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_cursor_row) < ROWS) && (32'(out_cursor_col) < COLUMNS))
    else $error("cursor off screen");

  // linear position agrees with row and column
  a_linear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_cursor_linear ==
      11'(32'(out_cursor_row) * COLUMNS + 32'(out_cursor_col)))
    else $error("cursor linear position mismatch");

  // clear transaction sweeps the store before it reports
  a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_op == tcw_pkg::OP_CLEAR) |=> busy && !out_valid)
    else $error("clear reported too early");

  // in-range read waits in ST_READ for the memory
  a_read_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_op == tcw_pkg::OP_READ && (32'(in_read_row) < ROWS) &&
     (32'(in_read_col) < COLUMNS)) |=> busy && !out_valid)
    else $error("read reported without memory latency");

endmodule

bind text_console_writer_unit tcw_checker #(
  .COLUMNS(COLUMNS),
  .ROWS   (ROWS)
) u_tcw_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .in_op            (in_op),
  .in_read_row      (in_read_row),
  .in_read_col      (in_read_col),
  .out_valid        (out_valid),
  .out_cursor_row   (out_cursor_row),
  .out_cursor_col   (out_cursor_col),
  .out_cursor_linear(out_cursor_linear)
);

### tb/text_console_writer_unit_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for the text console writer: directed rows, then random phases
module text_console_writer_unit_tb;

  localparam int COLS        = 80;
  localparam int LINES       = 25;
  localparam int CELLS       = COLS * LINES;
  localparam int CYCLE_LIMIT = 6_000_000;
  localparam int ITEMS_PER_PHASE = 150;

  // one result transaction as seen on the out_ ports
  typedef struct packed {
    logic [7:0]  ch;
    logic [7:0]  colour;
    logic [4:0]  row;
    logic [6:0]  col;
    logic [10:0] linear;
  } report_t;

  // directed stimulus row, with an optional hand-typed result
  typedef struct packed {
    tcw_pkg::op_t op;
    logic [7:0]   ch;
    logic [4:0]   rr;
    logic [6:0]   rc;
    logic         typed;
    report_t      want;
  } dir_row_t;

  // random phase: colour, sender idling and the mix of operations and characters
  typedef struct packed {
    logic [7:0] colour;
    logic       rand_colour;
    int         idle_pct;
    int         read_pct;
    int         clear_pct;
    int         none_pct;
    int         nl_pct;
    int         bs_pct;
  } phase_t;

  localparam report_t NO_REPORT = '{8'd0, 8'd0, 5'd0, 7'd0, 11'd0};
  localparam report_t BLANK_HOME =
    '{tcw_pkg::CH_SPACE, tcw_pkg::RESET_COLOR, 5'd0, 7'd0, 11'd0};

  localparam int N_DIRECTED = 18;
  localparam dir_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    '{tcw_pkg::OP_READ,  8'h00,                 5'd0,  7'd0,   1'b1, BLANK_HOME},
    '{tcw_pkg::OP_PUT,   tcw_pkg::CH_BACKSPACE, 5'd0,  7'd0,   1'b1, NO_REPORT},
    '{tcw_pkg::OP_READ,  8'h00,                 5'd31, 7'd127, 1'b1, NO_REPORT},
    '{tcw_pkg::OP_READ,  8'h00,                 5'd24, 7'd79,  1'b1, BLANK_HOME},
    '{tcw_pkg::OP_NONE,  8'hff,                 5'd31, 7'd127, 1'b1, NO_REPORT},
    '{tcw_pkg::OP_PUT,   8'h41,                 5'd0,  7'd0,   1'b0, NO_REPORT},
    '{tcw_pkg::OP_PUT,   8'hff,                 5'd0,  7'd0,   1'b0, NO_REPORT},
    '{tcw_pkg::OP_PUT,   8'h00,                 5'd0,  7'd0,   1'b0, NO_REPORT},
    '{tcw_pkg::OP_READ,  8'h00,                 5'd0,  7'd1,   1'b0, NO_REPORT},
    '{tcw_pkg::OP_PUT,   tcw_pkg::CH_NEWLINE,   5'd0,  7'd0,   1'b0, NO_REPORT},
    '{tcw_pkg::OP_PUT,   tcw_pkg::CH_BACKSPACE, 5'd0,  7'd0,   1'b0, NO_REPORT},
    '{tcw_pkg::OP_READ,  8'h00,                 5'd0,  7'd79,  1'b0, NO_REPORT},
    '{tcw_pkg::OP_PUT,   8'h7f,                 5'd0,  7'd0,   1'b0, NO_REPORT},
    '{tcw_pkg::OP_READ,  8'h00,                 5'd25, 7'd0,   1'b0, NO_REPORT},
    '{tcw_pkg::OP_READ,  8'h00,                 5'd0,  7'd80,  1'b0, NO_REPORT},
    '{tcw_pkg::OP_READ,  8'h00,                 5'd0,  7'd64,  1'b0, NO_REPORT},
    '{tcw_pkg::OP_CLEAR, 8'h00,                 5'd0,  7'd0,   1'b1, NO_REPORT},
    '{tcw_pkg::OP_READ,  8'h00,                 5'd0,  7'd0,   1'b1, BLANK_HOME}
  };

  // plain mix, newline-heavy (reaches the bottom and scrolls), long text runs, editing, then the first two again
  localparam int N_PHASES = 6;
  localparam phase_t PHASES [N_PHASES] = '{
    '{8'h00, 1'b0, 0,  24, 2, 4, 6,  8},
    '{8'hff, 1'b0, 83, 17, 0, 3, 35, 5},
    '{8'h00, 1'b1, 38, 13, 0, 2, 1,  2},
    '{8'h00, 1'b1, 0,  30, 1, 4, 5,  45},
    '{8'ha5, 1'b0, 83, 24, 2, 4, 6,  8},
    '{8'h00, 1'b1, 38, 17, 0, 3, 35, 5}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_op = tcw_pkg::OP_NONE;
  logic [7:0]  in_char_code = 8'd0;
  logic [4:0]  in_read_row = 5'd0;
  logic [6:0]  in_read_col = 7'd0;
  logic        out_valid;
  logic [7:0]  out_cell_char;
  logic [7:0]  out_cell_color;
  logic [4:0]  out_cursor_row;
  logic [6:0]  out_cursor_col;
  logic [10:0] out_cursor_linear;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  text_console_writer_unit #(
    .COLUMNS(COLS),
    .ROWS(LINES)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_op(in_op),
    .in_char_code(in_char_code),
    .in_read_row(in_read_row),
    .in_read_col(in_read_col),
    .out_valid(out_valid),
    .out_cell_char(out_cell_char),
    .out_cell_color(out_cell_color),
    .out_cursor_row(out_cursor_row),
    .out_cursor_col(out_cursor_col),
    .out_cursor_linear(out_cursor_linear),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // shadow of the screen store, cursor and attribute
  logic [15:0] screen_shadow [CELLS];
  int          cur_row;
  int          cur_col;
  logic [7:0]  attr_shadow;

  report_t     expected_reports [$];
  int          mismatches = 0;
  int          cycle_count = 0;
  int          idle_pct = 0;

  // clock
  initial begin
    forever #1 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic note_mismatch(input string msg);
    if (mismatches < 10) $display("%s", msg);
    mismatches++;
  endtask

  // compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    report_t got;
    report_t want;
    if (rst_n && out_valid) begin
      got = '{out_cell_char, out_cell_color, out_cursor_row, out_cursor_col,
              out_cursor_linear};
      if (expected_reports.size() == 0) begin
        note_mismatch($sformatf("unexpected result: char %h colour %h row %0d col %0d lin %0d",
                                got.ch, got.colour, got.row, got.col, got.linear));
      end else begin
        want = expected_reports.pop_front();
        if (got !== want)
          note_mismatch({
            $sformatf("result mismatch: expected char %h colour %h row %0d col %0d lin %0d",
                      want.ch, want.colour, want.row, want.col, want.linear),
            $sformatf(", got char %h colour %h row %0d col %0d lin %0d",
                      got.ch, got.colour, got.row, got.col, got.linear)});
      end
    end
  end

  function automatic logic [15:0] blank_cell();
    return {attr_shadow, tcw_pkg::CH_SPACE};
  endfunction

  // cursor to the next line, scrolling the store up past the last row
  function automatic void advance_line();
    cur_col = 0;
    cur_row++;
    if (cur_row >= LINES) begin
      for (int i = 0; i + COLS < CELLS; i++) screen_shadow[i] = screen_shadow[i + COLS];
      for (int i = 0; i < COLS; i++) screen_shadow[(LINES - 1) * COLS + i] = blank_cell();
      cur_row = LINES - 1;
    end
  endfunction

  // expected result of one input transaction, updating the shadow state
  function automatic report_t console_step(tcw_pkg::op_t op, logic [7:0] ch,
                                           logic [4:0] rr, logic [6:0] rc);
    report_t r;
    r = NO_REPORT;
    case (op)
      tcw_pkg::OP_PUT: begin
        if (ch == tcw_pkg::CH_NEWLINE) begin
          advance_line();
        end else if (ch == tcw_pkg::CH_BACKSPACE) begin
          if (cur_col > 0) begin
            cur_col--;
            screen_shadow[cur_row * COLS + cur_col] = blank_cell();
          end else if (cur_row > 0) begin
            cur_row--;
            cur_col = COLS - 1;
            screen_shadow[cur_row * COLS + cur_col] = blank_cell();
          end
        end else begin
          screen_shadow[cur_row * COLS + cur_col] = {attr_shadow, ch};
          cur_col++;
          if (cur_col >= COLS) advance_line();
        end
      end
      tcw_pkg::OP_READ: begin
        if (rr < LINES && rc < COLS) {r.colour, r.ch} = screen_shadow[rr * COLS + rc];
      end
      tcw_pkg::OP_CLEAR: begin
        for (int i = 0; i < CELLS; i++) screen_shadow[i] = blank_cell();
        cur_row = 0;
        cur_col = 0;
      end
      default: ;
    endcase
    r.row = cur_row[4:0];
    r.col = cur_col[6:0];
    r.linear = 11'(cur_row * COLS + cur_col);
    return r;
  endfunction

  // one input transaction: random idle cycles, then hold start until accepted
  task automatic send(input tcw_pkg::op_t op, input logic [7:0] ch,
                      input logic [4:0] rr, input logic [6:0] rc,
                      input logic typed, input report_t want);
    report_t predicted;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    start        <= 1'b1;
    in_op        <= op;
    in_char_code <= ch;
    in_read_row  <= rr;
    in_read_col  <= rc;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = console_step(op, ch, rr, rc);
    expected_reports.push_back(typed ? want : predicted);
  endtask

  // sender pauses until every result has arrived and the block is idle
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (expected_reports.size() != 0 || busy) @(posedge clk);
  endtask

  // register write followed by a read-back
  task automatic set_colour(input logic [7:0] colour);
    for (int wr = 1; wr >= 0; wr--) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr[0];
      paddr   <= tcw_pkg::CFG_TEXT_COLOR_ADDR;
      pwdata  <= {24'd0, colour};
      @(posedge clk);
      penable <= 1'b1;
      @(posedge clk);
      while (!pready) @(posedge clk);
      if (wr == 0 && prdata[7:0] !== colour)
        note_mismatch($sformatf("colour read-back: expected %h got %h", colour, prdata[7:0]));
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clk);
    end
    attr_shadow = colour;
  endtask

  // stimulus: reset, directed rows, then random phases
  initial begin
    phase_t       ph;
    logic [7:0]   colour;
    tcw_pkg::op_t op;
    logic [7:0]   ch;
    logic [4:0]   rr;
    logic [6:0]   rc;
    int           roll;

    for (int i = 0; i < CELLS; i++) screen_shadow[i] = {tcw_pkg::RESET_COLOR, tcw_pkg::CH_SPACE};
    cur_row = 0;
    cur_col = 0;
    attr_shadow = tcw_pkg::RESET_COLOR;

    // reset
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows with the reset attribute
    idle_pct = 0;
    for (int i = 0; i < N_DIRECTED; i++)
      send(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].ch, DIRECTED_ROWS[i].rr,
           DIRECTED_ROWS[i].rc, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);

    for (int p = 0; p < N_PHASES; p++) begin
      ph = PHASES[p];
      drain();
      colour = ph.rand_colour ? 8'($urandom) : ph.colour;
      set_colour(colour);
      idle_pct = ph.idle_pct;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        roll = $urandom_range(99);
        ch = 8'($urandom);
        rr = 5'($urandom);
        rc = 7'($urandom);
        if (roll < ph.read_pct) begin
          op = tcw_pkg::OP_READ;
          // half the reads look at the line being written
          if ($urandom_range(1) == 1) begin
            rr = cur_row[4:0];
            rc = 7'($urandom_range(0, cur_col));
          end
        end else if (roll < ph.read_pct + ph.clear_pct) begin
          op = tcw_pkg::OP_CLEAR;
        end else if (roll < ph.read_pct + ph.clear_pct + ph.none_pct) begin
          op = tcw_pkg::OP_NONE;
        end else begin
          op = tcw_pkg::OP_PUT;
          roll = $urandom_range(99);
          if (roll < ph.nl_pct) ch = tcw_pkg::CH_NEWLINE;
          else if (roll < ph.nl_pct + ph.bs_pct) ch = tcw_pkg::CH_BACKSPACE;
        end
        send(op, ch, rr, rc, 1'b0, NO_REPORT);
      end
    end

    // let the last transactions settle
    drain();
    repeat (50) @(posedge clk);
    if (mismatches == 0 && expected_reports.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
